### sv/postfix_stack_calculator_defines.svh
// assertion macros for the postfix stack calculator
`ifndef POSTFIX_STACK_CALCULATOR_DEFINES_SVH
`define POSTFIX_STACK_CALCULATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/psc_pkg.sv
package psc_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int STEP_W      = $clog2(DATA_WIDTH);
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_NEG  = 3'd5,
		OP_POP  = 3'd6,
		OP_NOP  = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_UNDER   = 2'd1,
		ST_OVER    = 2'd2,
		ST_DIVZERO = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD,
		S_ALU,
		S_DIV_NUM,
		S_DIV_DEN,
		S_DIV_STEP,
		S_DIV_FIX,
		S_DONE
	} state_t;

endpackage

### sv/postfix_stack_calculator.sv
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    operation, operand_value
// result    out        result_valid / result_stall top_value, stack_depth, status
//
// one item at a time: item_stall is high from the transfer until the result is loaded
// into the output register; push, lone pop, no-op, underflow and overflow go from decode
// to done; negate via ALU; pop with a second entry and divide by zero via load; add/sub/mul
// via load and ALU; divide: load, magnitudes, one quotient bit per cycle, 32 steps, sign fix
// a new item is taken while the previous result still waits behind result_stall
// arst_n clears the sequencer, entry count and output valid; stack entries are not cleared

`include "postfix_stack_calculator_defines.svh"

module postfix_stack_calculator import psc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [DATA_WIDTH-1:0] operand_value,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [DATA_WIDTH-1:0] top_value,
	output logic [CNT_W-1:0]           stack_depth,
	output logic [STATUS_W-1:0]        status
);

	// sequencer and control state
	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic result_valid_q;

	// item and datapath registers
	op_t op_q;
	data_t opnd_q;
	data_t top_q;      // top of stack is kept in a register, the rest in memory
	data_t sec_q;      // registered memory read: the entry below the top
	data_t quo_q;
	data_t rem_q;
	data_t den_q;
	logic qneg_q;
	logic [STEP_W-1:0] step_q;
	status_t status_q;

	// output register
	data_t top_value_q;
	logic [CNT_W-1:0] stack_depth_q;
	status_t status_out_q;

	// stack memory below the top entry
	data_t stack_mem [STACK_DEPTH];

	// memory control
	logic mem_we;
	logic mem_rd_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	// shared adder/subtractor, one bit wider for the divide trial subtract
	logic [DATA_WIDTH:0] alu_a;
	logic [DATA_WIDTH:0] alu_b;
	logic alu_sub;
	logic [DATA_WIDTH:0] alu_sum;

	data_t mul_lo;

	logic is_empty;
	logic is_full;
	logic has_two;
	logic done_go;
	logic [CNT_W-1:0] count_m1;
	logic [CNT_W-1:0] count_m2;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign has_two  = (count_q >= CNT_W'(2));
	assign count_m1 = count_q - CNT_W'(1);
	assign count_m2 = count_q - CNT_W'(2);
	assign wr_addr  = count_m1[ADDR_W-1:0];
	assign rd_addr  = count_m2[ADDR_W-1:0];

	// output register is free, or its result leaves this cycle
	assign done_go = !result_valid_q || !result_stall;

	assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + (DATA_WIDTH + 1)'(alu_sub);

	// low half of the product, registered into top_q
	assign mul_lo = sec_q * top_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (op_q)
					OP_PUSH: state_d = S_DONE;
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_d = has_two ? S_LOAD : S_DONE;
					OP_NEG: state_d = is_empty ? S_DONE : S_ALU;
					OP_POP: state_d = has_two ? S_LOAD : S_DONE;
					OP_NOP: state_d = S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_LOAD: begin
				priority if (op_q == OP_POP) state_d = S_DONE;
				else if (op_q == OP_DIV) state_d = (top_q == '0) ? S_DONE : S_DIV_NUM;
				else state_d = S_ALU;
			end
			S_ALU:      state_d = S_DONE;
			S_DIV_NUM:  state_d = S_DIV_DEN;
			S_DIV_DEN:  state_d = S_DIV_STEP;
			S_DIV_STEP: begin
				if (step_q == '0) state_d = S_DIV_FIX;
			end
			S_DIV_FIX:  state_d = S_DONE;
			S_DONE: begin
				if (done_go) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: memory strobes and shared unit operands
	always_comb begin
		mem_we    = 1'b0;
		mem_rd_en = 1'b0;
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b0;
		unique case (state_q)
			S_DECODE: begin
				// push spills the old top into memory
				mem_we = (op_q == OP_PUSH) && !is_full && !is_empty;
				mem_rd_en = has_two && (op_q == OP_ADD || op_q == OP_SUB ||
					op_q == OP_MUL || op_q == OP_DIV || op_q == OP_POP);
			end
			S_ALU: begin
				unique case (op_q)
					OP_ADD: begin
						alu_a = {1'b0, sec_q};
						alu_b = {1'b0, top_q};
					end
					OP_SUB: begin
						alu_a   = {1'b0, sec_q};
						alu_b   = {1'b0, top_q};
						alu_sub = 1'b1;
					end
					OP_NEG: begin
						alu_b   = {1'b0, top_q};
						alu_sub = 1'b1;
					end
					default: begin
						alu_sub = 1'b0;
					end
				endcase
			end
			S_DIV_NUM: begin
				alu_b   = {1'b0, sec_q};
				alu_sub = 1'b1;
			end
			S_DIV_DEN: begin
				alu_b   = {1'b0, top_q};
				alu_sub = 1'b1;
			end
			S_DIV_STEP: begin
				// trial subtract of the divisor from the shifted partial remainder
				alu_a   = {rem_q, quo_q[DATA_WIDTH-1]};
				alu_b   = {1'b0, den_q};
				alu_sub = 1'b1;
			end
			S_DIV_FIX: begin
				alu_b   = {1'b0, quo_q};
				alu_sub = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == S_DECODE && op_q == OP_PUSH && !is_full)
				count_q <= count_q + CNT_W'(1);
			else if (state_q == S_DECODE && op_q == OP_POP && !is_empty)
				count_q <= count_m1;
			else if (state_q == S_ALU && op_q != OP_NEG)
				count_q <= count_m1;
			else if (state_q == S_DIV_FIX)
				count_q <= count_m1;

			if (state_q == S_DONE && done_go)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) stack_mem[wr_addr] <= top_q;
		if (mem_rd_en) sec_q <= stack_mem[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					op_q   <= op_t'(operation);
					opnd_q <= data_t'(operand_value);
				end
			end
			S_DECODE: begin
				unique case (op_q)
					OP_PUSH: begin
						status_q <= is_full ? ST_OVER : ST_OK;
						if (!is_full) top_q <= opnd_q;
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						status_q <= has_two ? ST_OK : ST_UNDER;
					end
					OP_NEG, OP_POP: begin
						status_q <= is_empty ? ST_UNDER : ST_OK;
					end
					default: begin
						status_q <= ST_OK;
					end
				endcase
			end
			S_LOAD: begin
				if (op_q == OP_POP) top_q <= sec_q;
				if (op_q == OP_DIV && top_q == '0) status_q <= ST_DIVZERO;
			end
			S_ALU: begin
				if (op_q == OP_MUL) top_q <= mul_lo;
				else top_q <= alu_sum[DATA_WIDTH-1:0];
			end
			S_DIV_NUM: begin
				// magnitude of the dividend, quotient sign from both operands
				quo_q  <= sec_q[DATA_WIDTH-1] ? alu_sum[DATA_WIDTH-1:0] : sec_q;
				qneg_q <= sec_q[DATA_WIDTH-1] ^ top_q[DATA_WIDTH-1];
				rem_q  <= '0;
				step_q <= STEP_W'(DATA_WIDTH - 1);
			end
			S_DIV_DEN: begin
				den_q <= top_q[DATA_WIDTH-1] ? alu_sum[DATA_WIDTH-1:0] : top_q;
			end
			S_DIV_STEP: begin
				// restoring step: keep the difference when it did not go negative
				if (!alu_sum[DATA_WIDTH]) rem_q <= alu_sum[DATA_WIDTH-1:0];
				else rem_q <= {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
				quo_q  <= {quo_q[DATA_WIDTH-2:0], !alu_sum[DATA_WIDTH]};
				step_q <= step_q - STEP_W'(1);
			end
			S_DIV_FIX: begin
				top_q <= qneg_q ? alu_sum[DATA_WIDTH-1:0] : quo_q;
			end
			S_DONE: begin
				if (done_go) begin
					top_value_q   <= is_empty ? '0 : top_q;
					stack_depth_q <= count_q;
					status_out_q  <= status_q;
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign top_value    = signed'(top_value_q);
	assign stack_depth  = stack_depth_q;
	assign status       = status_out_q;

	// entry count stays within the stack
	`PSC_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "entry count beyond stack depth")

	// overflow is only reported on a full stack
	`PSC_ASSERT_NOW(a_over_full, result_valid && status == ST_OVER, stack_depth == CNT_W'(STACK_DEPTH), "overflow reported below full depth")

	// underflow is only reported with fewer than two entries
	`PSC_ASSERT_NOW(a_under_shallow, result_valid && status == ST_UNDER, stack_depth < CNT_W'(2), "underflow reported with two or more entries")

	// last quotient step hands over to the sign fix
	`PSC_ASSERT_NEXT(a_div_done, state_q == S_DIV_STEP && step_q == '0, state_q == S_DIV_FIX, "divider did not finish after last step")

endmodule

### tb/sv/tb.sv
module tb;
	import psc_pkg::*;

	// run bounds: the slowest item is a divide, so even with every transfer
	// stalled on both sides the run stays well inside the limit
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 48;
	localparam int unsigned MAX_GAP      = 20;

	// one result: new top, entry count and status
	typedef struct {
		data_t              top;
		logic [CNT_W-1:0]   depth;
		status_t            st;
	} result_t;

	// directed row: operation, operand, how many times it is sent, and a
	// hand-written result for the last send where it is obvious
	typedef struct {
		op_t         op;
		data_t       val;
		int unsigned reps;
		bit          typed;
		result_t     want;
	} step_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_stall;
	logic [OP_W-1:0]              operation;
	logic signed [DATA_WIDTH-1:0] operand_value;
	logic                         result_valid;
	logic                         result_stall;
	logic signed [DATA_WIDTH-1:0] top_value;
	logic [CNT_W-1:0]             stack_depth;
	logic [STATUS_W-1:0]          status;

	// shadow copy of the stack, advanced on every accepted item
	data_t       shadow_stack [STACK_DEPTH];
	int unsigned shadow_depth = 0;

	result_t     pending_results [$];
	result_t     last_seen;
	int unsigned items_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count   = 0;
	int unsigned tx_idle_pct   = 0;
	int unsigned rx_idle_pct   = 0;
	bit          hold_req      = 1'b0;

	// directed walk: empty-stack errors, wrap at the extremes, the most negative
	// value divided by minus one and negated, divide by zero, the no-op,
	// filling past the top, and emptying past the bottom
	step_row_t directed_rows [25] = '{
		'{OP_POP,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_UNDER}},
		'{OP_NEG,  32'hffff_ffff, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_UNDER}},
		'{OP_ADD,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_UNDER}},
		'{OP_PUSH, 32'h7fff_ffff, 1,  1'b1, '{32'h7fff_ffff, 5'd1,  ST_OK}},
		'{OP_DIV,  32'h0000_0000, 1,  1'b1, '{32'h7fff_ffff, 5'd1,  ST_UNDER}},
		'{OP_PUSH, 32'h0000_0001, 1,  1'b1, '{32'h0000_0001, 5'd2,  ST_OK}},
		'{OP_ADD,  32'h0000_0000, 1,  1'b1, '{32'h8000_0000, 5'd1,  ST_OK}},
		'{OP_PUSH, 32'hffff_ffff, 1,  1'b1, '{32'hffff_ffff, 5'd2,  ST_OK}},
		'{OP_DIV,  32'h0000_0000, 1,  1'b1, '{32'h8000_0000, 5'd1,  ST_OK}},
		'{OP_NEG,  32'h0000_0000, 1,  1'b1, '{32'h8000_0000, 5'd1,  ST_OK}},
		'{OP_PUSH, 32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd2,  ST_OK}},
		'{OP_DIV,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd2,  ST_DIVZERO}},
		'{OP_POP,  32'h0000_0000, 1,  1'b1, '{32'h8000_0000, 5'd1,  ST_OK}},
		'{OP_NOP,  32'h1234_5678, 1,  1'b1, '{32'h8000_0000, 5'd1,  ST_OK}},
		'{OP_PUSH, 32'hffff_fff9, 1,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_DIV,  32'h0000_0000, 1,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_PUSH, 32'h0001_0003, 1,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_MUL,  32'h0000_0000, 1,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_PUSH, 32'h0000_0003, 1,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_SUB,  32'h0000_0000, 1,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_PUSH, 32'h5a5a_5a5a, 18, 1'b1, '{32'h5a5a_5a5a, 5'd16, ST_OVER}},
		'{OP_MUL,  32'h0000_0000, 8,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_SUB,  32'h0000_0000, 8,  1'b0, '{32'h0000_0000, 5'd0,  ST_OK}},
		'{OP_POP,  32'h0000_0000, 2,  1'b1, '{32'h0000_0000, 5'd0,  ST_UNDER}},
		'{OP_PUSH, 32'h8000_0000, 1,  1'b1, '{32'h8000_0000, 5'd1,  ST_OK}}
	};

	postfix_stack_calculator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.operand_value (operand_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.top_value     (top_value),
		.stack_depth   (stack_depth),
		.status        (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one stack step on the shadow state; returns the result it must produce
	function automatic result_t evaluate_item(input op_t op, input data_t val);
		result_t r;
		data_t   lhs;
		data_t   rhs;
		data_t   mag_lhs;
		data_t   mag_rhs;
		data_t   quo;
		data_t   outcome;
		r.st = ST_OK;
		case (op)
			OP_PUSH: begin
				if (shadow_depth >= STACK_DEPTH) begin
					r.st = ST_OVER;
				end else begin
					shadow_stack[shadow_depth] = val;
					shadow_depth++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (shadow_depth < 2) begin
					r.st = ST_UNDER;
				end else begin
					rhs = shadow_stack[shadow_depth - 1];
					lhs = shadow_stack[shadow_depth - 2];
					// zero divisor is only looked at once two entries exist
					if (op == OP_DIV && rhs == '0) begin
						r.st = ST_DIVZERO;
					end else begin
						case (op)
							OP_ADD: outcome = lhs + rhs;
							OP_SUB: outcome = lhs - rhs;
							OP_MUL: outcome = lhs * rhs;
							default: begin
								// truncating divide on magnitudes, sign fixed after;
								// most negative over minus one wraps back to itself
								mag_lhs = lhs[DATA_WIDTH-1] ? -lhs : lhs;
								mag_rhs = rhs[DATA_WIDTH-1] ? -rhs : rhs;
								quo     = mag_lhs / mag_rhs;
								outcome = (lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1]) ? -quo : quo;
							end
						endcase
						shadow_depth--;
						shadow_stack[shadow_depth - 1] = outcome;
					end
				end
			end
			OP_NEG: begin
				if (shadow_depth == 0) begin
					r.st = ST_UNDER;
				end else begin
					shadow_stack[shadow_depth - 1] = -shadow_stack[shadow_depth - 1];
				end
			end
			OP_POP: begin
				if (shadow_depth == 0) begin
					r.st = ST_UNDER;
				end else begin
					shadow_depth--;
				end
			end
			default: ;
		endcase
		r.top   = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth - 1];
		r.depth = CNT_W'(shadow_depth);
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void check_result(input string tag, input result_t want, input result_t got);
		if (got.top !== want.top || got.depth !== want.depth || got.st !== want.st) begin
			note_failure($sformatf({"%s mismatch: expected top %h depth %0d status %0d, ",
				"got top %h depth %0d status %0d"}, tag, want.top, want.depth, want.st,
				got.top, got.depth, got.st));
		end
	endfunction

	// input side: every accepted transfer queues its expected result
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			pending_results.push_back(evaluate_item(op_t'(operation), data_t'(operand_value)));
		end
	end

	// output side: every accepted transfer is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			last_seen.top   = top_value;
			last_seen.depth = stack_depth;
			last_seen.st    = status_t'(status);
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: top %h depth %0d status %0d",
					top_value, stack_depth, status));
			end else begin
				check_result("result", pending_results.pop_front(), last_seen);
			end
		end
	end

	// receiver: random stall, or a long hold-off counted down here when requested
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// operand mix: corner values, small numbers around zero, and full random bits
	function automatic data_t pick_value();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			5, 6: return data_t'($urandom_range(20)) - 32'd10;
			default: return data_t'($urandom());
		endcase
	endfunction

	// offer one item after a random gap and hold it until the transfer;
	// valid stays high on return so back-to-back items need no second assignment
	task automatic send_item(input op_t op, input data_t val);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid    <= 1'b1;
		operation     <= op;
		operand_value <= val;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	// drop valid and wait for every sent item to come back
	task automatic drain_results();
		item_valid <= 1'b0;
		while (results_seen < items_sent) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		int unsigned operands;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// well-formed expression: operands first, then operators
				operands = $urandom_range(4, 1);
				repeat (operands) send_item(OP_PUSH, pick_value());
				repeat (operands - 1) begin
					if ($urandom_range(4) == 0) begin
						send_item(OP_NEG, pick_value());
					end
					send_item(op_t'($urandom_range(int'(OP_DIV), int'(OP_ADD))), pick_value());
				end
				if ($urandom_range(1) != 0) begin
					send_item(OP_POP, pick_value());
				end
			end else if (pick < 63) begin
				// push burst that usually runs into the top, then fold back down
				repeat ($urandom_range(18, 12)) send_item(OP_PUSH, pick_value());
				repeat ($urandom_range(14, 6))
					send_item(op_t'($urandom_range(int'(OP_DIV), int'(OP_ADD))), pick_value());
			end else if (pick < 75) begin
				// pop run, often past the bottom
				repeat ($urandom_range(16, 1)) send_item(OP_POP, pick_value());
			end else begin
				// noise: any code including the no-op
				repeat ($urandom_range(4, 1)) send_item(op_t'($urandom_range(7)), pick_value());
			end
		end
	endtask

	initial begin
		item_valid    <= 1'b0;
		operation     <= OP_PUSH;
		operand_value <= '0;
		arst_n        <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, one item in flight at a time so hand-typed rows can be
		// read off the last result
		tx_idle_pct = 13;
		rx_idle_pct = 52;
		foreach (directed_rows[i]) begin
			for (int unsigned r = 0; r < directed_rows[i].reps; r++) begin
				send_item(directed_rows[i].op, directed_rows[i].val);
				drain_results();
			end
			if (directed_rows[i].typed) begin
				check_result($sformatf("directed row %0d", i), directed_rows[i].want, last_seen);
			end
		end

		// sender mostly busy, receiver stalls often
		run_random(370);
		drain_results();

		// roles swapped
		tx_idle_pct = 52;
		rx_idle_pct = 13;
		run_random(370);
		drain_results();

		// no idling; a long receiver hold-off backs the block up into its input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b1;
		run_random(360);
		drain_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
		end
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
